// ===== rtl/wfba_pkg.sv =====
package wfba_pkg;

  // Width of the request and the returned start address on the ports.
  localparam int unsigned REQ_W = 11;
  localparam int unsigned ADDR_W = 11;

  localparam int unsigned DEF_TABLE_DEPTH = 64;
  localparam int unsigned DEF_MEM_SIZE = 1024;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DONE
  } wfba_state_t;

endpackage

// ===== rtl/wfba_cell.sv =====
module wfba_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned MEM_SIZE = 1024,
  localparam int unsigned LW = $clog2(MEM_SIZE + 1),
  localparam int unsigned IW = $clog2(TABLE_DEPTH),
  localparam int unsigned CW = (LW > wfba_pkg::REQ_W) ? LW : wfba_pkg::REQ_W
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [wfba_pkg::REQ_W-1:0] req,
  // Running best candidate from the previous cell.
  input  logic                       found_in,
  input  logic [LW-1:0]              rem_in,
  input  logic [IW-1:0]              pick_in,
  input  logic [LW-1:0]              start_in,
  output logic                       found_out,
  output logic [LW-1:0]              rem_out,
  output logic [IW-1:0]              pick_out,
  output logic [LW-1:0]              start_out,
  // Final result of the search, broadcast for the update.
  input  logic                       upd_en,
  input  logic                       fin_found,
  input  logic [LW-1:0]              fin_rem,
  input  logic [IW-1:0]              fin_pick,
  input  logic [LW-1:0]              rem_start,
  // Entry of the previous cell, for the shift on insert.
  input  logic [LW-1:0]              prev_start,
  input  logic [LW-1:0]              prev_len,
  input  logic                       prev_taken,
  output logic [LW-1:0]              ent_start,
  output logic [LW-1:0]              ent_len,
  output logic                       ent_taken
);
  import wfba_pkg::*;

  localparam logic [LW-1:0] RESET_LEN = (IDX == 0) ? LW'(MEM_SIZE) : '0;

  logic [CW-1:0] req_ext;
  logic [CW-1:0] len_ext;
  logic          fits;
  logic [LW-1:0] my_rem;
  logic          take;
  logic [IW:0]   self_idx;
  logic [IW:0]   after_pick;
  logic          shift;

  always_comb begin
    req_ext = CW'(req);
    len_ext = CW'(ent_len);
    fits = !ent_taken && (len_ext >= req_ext);
    my_rem = LW'(len_ext - req_ext);
    // Strictly larger wins, so the lower index keeps a tie.
    take = fits && (!found_in || (my_rem > rem_in));
    self_idx = (IW + 1)'(IDX);
    after_pick = {1'b0, fin_pick} + (IW + 1)'(1);
    shift = fin_rem != '0;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      found_out <= 1'b1;
      rem_out <= my_rem;
      pick_out <= IW'(IDX);
      start_out <= ent_start;
    end else begin
      found_out <= found_in;
      rem_out <= rem_in;
      pick_out <= pick_in;
      start_out <= start_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ent_start <= '0;
      ent_len <= RESET_LEN;
      ent_taken <= 1'b0;
    end else if (upd_en && fin_found) begin
      if (self_idx == {1'b0, fin_pick}) begin
        ent_taken <= 1'b1;
        ent_len <= LW'(req_ext);
      end else if (shift && (self_idx == after_pick)) begin
        ent_start <= rem_start;
        ent_len <= fin_rem;
        ent_taken <= 1'b0;
      end else if (shift && (self_idx > after_pick)) begin
        ent_start <= prev_start;
        ent_len <= prev_len;
        ent_taken <= prev_taken;
      end
    end
  end

endmodule

// ===== rtl/worst_fit_block_allocator.sv =====
// Worst-fit block allocator. The block keeps an ordered table of memory
// blocks (start, length, taken mark); after reset, entry 0 is one free block
// covering all MEM_SIZE units and every other entry is a free block of length
// zero. Each request beat carries a size and produces exactly one result
// beat: granted is 1 with the start address of the free entry that leaves the
// largest remainder (lowest index on ties), or granted is 0 with address 0
// when nothing fits. A nonzero remainder is inserted as a free entry right
// after the chosen one, pushing later entries up and dropping the last. The
// result is loaded into the output register once the search and the update
// are done: the search is a wavefront that moves one table cell per cycle
// down the chain of TABLE_DEPTH cells, followed by the update, in which every
// cell applies the mark, insert and shift at once; the update waits until the
// output register is free. The next request is accepted in the cycle after the
// result is loaded into the output register, even if that result is still
// stalled, so no new request is taken while a search or update is under way.
module worst_fit_block_allocator #(
  parameter int unsigned TABLE_DEPTH = wfba_pkg::DEF_TABLE_DEPTH,
  parameter int unsigned MEM_SIZE = wfba_pkg::DEF_MEM_SIZE
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [wfba_pkg::REQ_W-1:0]  req_size,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        granted,
  output logic [wfba_pkg::ADDR_W-1:0] start_addr
);
  import wfba_pkg::*;

  localparam int unsigned LW = $clog2(MEM_SIZE + 1);
  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW = (LW > REQ_W) ? LW : REQ_W;

  wfba_state_t state;
  wfba_state_t state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic [REQ_W-1:0] req;

  logic accept_in;
  logic upd_en;

  // The search chain: element k feeds cell k, element TABLE_DEPTH is the result.
  logic          found_c [0:TABLE_DEPTH];
  logic [LW-1:0] rem_c   [0:TABLE_DEPTH];
  logic [IW-1:0] pick_c  [0:TABLE_DEPTH];
  logic [LW-1:0] start_c [0:TABLE_DEPTH];

  logic [LW-1:0] ent_start [0:TABLE_DEPTH-1];
  logic [LW-1:0] ent_len   [0:TABLE_DEPTH-1];
  logic          ent_taken [0:TABLE_DEPTH-1];

  logic [LW-1:0] rem_start;

  // The search wave starts empty at the head of the chain.
  assign found_c[0] = 1'b0;
  assign rem_c[0] = '0;
  assign pick_c[0] = '0;
  assign start_c[0] = '0;

  // The remainder starts right after the granted part; it never passes MEM_SIZE
  // when the grant is real.
  assign rem_start = LW'(CW'(start_c[TABLE_DEPTH]) + CW'(req));

  genvar g;
  generate
    for (g = 0; g < TABLE_DEPTH; g++) begin : g_cell
      logic [LW-1:0] prev_start;
      logic [LW-1:0] prev_len;
      logic          prev_taken;

      if (g == 0) begin : g_head
        // Entry 0 is never the target of a shift.
        assign prev_start = '0;
        assign prev_len = '0;
        assign prev_taken = 1'b0;
      end else begin : g_body
        assign prev_start = ent_start[g-1];
        assign prev_len = ent_len[g-1];
        assign prev_taken = ent_taken[g-1];
      end

      wfba_cell #(
        .IDX(g),
        .TABLE_DEPTH(TABLE_DEPTH),
        .MEM_SIZE(MEM_SIZE)
      ) u_cell (
        .clk(clk),
        .rst(rst),
        .req(req),
        .found_in(found_c[g]),
        .rem_in(rem_c[g]),
        .pick_in(pick_c[g]),
        .start_in(start_c[g]),
        .found_out(found_c[g+1]),
        .rem_out(rem_c[g+1]),
        .pick_out(pick_c[g+1]),
        .start_out(start_c[g+1]),
        .upd_en(upd_en),
        .fin_found(found_c[TABLE_DEPTH]),
        .fin_rem(rem_c[TABLE_DEPTH]),
        .fin_pick(pick_c[TABLE_DEPTH]),
        .rem_start(rem_start),
        .prev_start(prev_start),
        .prev_len(prev_len),
        .prev_taken(prev_taken),
        .ent_start(ent_start[g]),
        .ent_len(ent_len[g]),
        .ent_taken(ent_taken[g])
      );
    end
  endgenerate

  // The request size is held for the whole search and the update.
  always_ff @(posedge clk) begin
    if (accept_in) begin
      req <= req_size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // The table only changes in the update cycle, so once the search has passed
  // all TABLE_DEPTH cells the tail of the chain holds the settled winner.
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    in_stall = 1'b1;
    upd_en = 1'b0;
    accept_in = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept_in = in_valid;
        if (in_valid) begin
          state_next = ST_SEARCH;
          cnt_next = '0;
        end
      end
      ST_SEARCH: begin
        cnt_next = cnt + CNT_W'(1);
        if (cnt == CNT_W'(TABLE_DEPTH - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // Wait until the output register is free before committing.
        if (!out_valid || !out_stall) begin
          upd_en = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_en) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      granted <= found_c[TABLE_DEPTH];
      if (found_c[TABLE_DEPTH]) begin
        start_addr <= ADDR_W'(start_c[TABLE_DEPTH]);
      end else begin
        start_addr <= '0;
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wfba_pkg::*;

  // The block runs at its default size, so the shadow table matches it.
  localparam int unsigned TABLE_DEPTH = DEF_TABLE_DEPTH;
  localparam int unsigned MEM_SIZE = DEF_MEM_SIZE;

  // After the last result has come out, we wait longer than one request beat
  // takes inside the block before the final verdict, so that a stray extra
  // beat would still be caught.
  localparam int unsigned TAIL_CYCLES = TABLE_DEPTH + 40;

  // The timeout is far above the slowest correct run. That run is about
  // 1700 beats, each taking the block's search and update, the longest receiver
  // stall and the longest sender gap, plus the long hold-offs.
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_BEATS = 1660;

  typedef struct packed {
    logic              granted;
    logic [ADDR_W-1:0] start_addr;
  } alloc_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [REQ_W-1:0]  req_size = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              granted;
  logic [ADDR_W-1:0] start_addr;

  // Shadow copy of the block table that the predictor keeps in step with
  // the block. Every accepted request beat updates it in acceptance order.
  logic [ADDR_W-1:0] tbl_start [TABLE_DEPTH];
  logic [ADDR_W-1:0] tbl_len [TABLE_DEPTH];
  logic              tbl_taken [TABLE_DEPTH];

  // Results predicted for accepted requests that have not come out yet.
  alloc_result_t grants_due[$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Idling controls. The test tasks write them, the driver and the
  // receiver process read them.
  bit sender_idles = 1'b0;
  bit receiver_idles = 1'b0;

  // A long hold-off is requested by raising holds_asked. The receiver
  // process serves it and counts the cycles itself.
  int unsigned holds_asked = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  worst_fit_block_allocator #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .MEM_SIZE(MEM_SIZE)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_size(req_size),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .granted(granted),
    .start_addr(start_addr)
  );

  always #10 clk = ~clk;

  // Timeout guard. A hung block or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL worst_fit_block_allocator");
      $finish;
    end
  end

  // Puts the shadow table into its reset shape: one free block over the
  // whole memory in entry 0, and free blocks of length zero elsewhere.
  task automatic clear_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_start[i] = '0;
      tbl_len[i] = '0;
      tbl_taken[i] = 1'b0;
    end
    tbl_len[0] = ADDR_W'(MEM_SIZE);
  endtask

  // Worst-fit choice over the shadow table. Among the free entries that are
  // long enough, the one that leaves the largest remainder wins, and the
  // strict comparison keeps the lowest index on a tie. A size of zero fits
  // every free entry, the empty ones included.
  function automatic alloc_result_t allocate_worst_fit(input logic [REQ_W-1:0] size);
    alloc_result_t     res;
    int                pick;
    bit                found;
    logic [ADDR_W-1:0] best;
    logic [ADDR_W-1:0] leftover;
    res = '0;
    pick = 0;
    found = 1'b0;
    best = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!tbl_taken[i] && tbl_len[i] >= size) begin
        leftover = tbl_len[i] - size;
        if (!found || leftover > best) begin
          found = 1'b1;
          best = leftover;
          pick = i;
        end
      end
    end
    // Nothing fits: refused, address zero, table untouched.
    if (!found) begin
      return res;
    end
    res.granted = 1'b1;
    res.start_addr = tbl_start[pick];
    tbl_taken[pick] = 1'b1;
    // A nonzero remainder becomes a free entry right after the chosen one.
    // Later entries move up and the one in the last place falls off. When
    // the chosen entry is itself the last one, the remainder is simply lost.
    if (best != 0 && pick + 1 < TABLE_DEPTH) begin
      for (int i = TABLE_DEPTH - 1; i > pick + 1; i--) begin
        tbl_start[i] = tbl_start[i - 1];
        tbl_len[i] = tbl_len[i - 1];
        tbl_taken[i] = tbl_taken[i - 1];
      end
      tbl_start[pick + 1] = tbl_start[pick] + size;
      tbl_len[pick + 1] = best;
      tbl_taken[pick + 1] = 1'b0;
    end
    tbl_len[pick] = size;
    return res;
  endfunction

  // Length of the largest free block, used to aim requests at exact fits
  // and at sizes just one unit too large.
  function automatic int unsigned largest_free();
    int unsigned biggest;
    biggest = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (!tbl_taken[i] && tbl_len[i] > biggest) begin
        biggest = 32'(tbl_len[i]);
      end
    end
    return biggest;
  endfunction

  // Sender gaps: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(10, 80);
  endfunction

  // Offers one request beat and holds it steady until the block takes it.
  // The expected result is worked out at the edge of acceptance, so the
  // shadow table follows the block in the same order. The valid is only
  // lowered when a gap follows, so back-to-back beats keep it high.
  task automatic send_request(input logic [REQ_W-1:0] size);
    int unsigned gap;
    in_valid <= 1'b1;
    req_size <= size;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    grants_due.push_back(allocate_worst_fit(size));
    gap = sender_idles ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Waits, edge by edge, until every predicted result has been checked.
  // The sender goes quiet first, so the beat just taken is not offered again.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Receiver side. It owns out_stall and drives it once per edge. A long
  // hold-off takes priority; otherwise it stalls at random when idling is
  // enabled, mostly briefly and now and then for a long stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (holds_asked != holds_served) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!receiver_idles) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: begin
          out_stall <= 1'b0;
        end
        [70:94]: begin
          stall_left <= $urandom_range(0, 2);
          out_stall <= 1'b1;
        end
        default: begin
          stall_left <= $urandom_range(10, 60);
          out_stall <= 1'b1;
        end
      endcase
    end
  end

  // Result checker. Every beat the block hands over is compared with the
  // oldest prediction; a beat with nothing predicted is an error too.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (grants_due.size() == 0) begin
        $display("%0t: unexpected result beat, granted %0b start_addr %0d",
                 $realtime, granted, start_addr);
        fail_count = fail_count + 1;
      end else begin
        want = grants_due.pop_front();
        if (granted !== want.granted) begin
          $display("%0t: granted mismatch, expected %0b actual %0b",
                   $realtime, want.granted, granted);
          fail_count = fail_count + 1;
        end
        if (start_addr !== want.start_addr) begin
          $display("%0t: start_addr mismatch, expected %0d actual %0d",
                   $realtime, want.start_addr, start_addr);
          fail_count = fail_count + 1;
        end
      end
    end
  end

  // Directed beats from the reset state. A zero-size request first takes
  // the whole-memory entry and reinserts it as a free remainder. Then come
  // small requests, a request for the whole memory and one for 1023 units
  // that no longer fit, zero-size requests that meet other free blocks, and
  // a spread of powers of two.
  task automatic test_directed_sizes();
    logic [REQ_W-1:0] sizes[$];
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    sizes = '{11'd0, 11'd1, 11'd2, 11'd1024, 11'd1023, 11'd0, 11'd0, 11'd3,
              11'd5, 11'd8, 11'd16, 11'd32, 11'd64, 11'd127, 11'd128, 11'd1,
              11'd0, 11'd2, 11'd4, 11'd1021};
    foreach (sizes[i]) begin
      send_request(sizes[i]);
    end
    // The sender pauses here until the block has answered everything.
    wait_all_results();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // that the block's output register and search both fill and in_stall
  // rises. The run goes on once the hold is over.
  task automatic test_output_backpressure();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    holds_asked = holds_asked + 1;
    for (int i = 0; i < 6; i++) begin
      send_request(REQ_W'($urandom_range(0, 6)));
    end
    wait_all_results();
  endtask

  // Mostly small requests with random content, mixed with exact fits of
  // the largest free block, requests one unit too large, zero sizes and
  // arbitrary sizes over the full range. Small sizes keep memory around
  // long enough for the table to fill with fragments, so that entries fall
  // off the top and the last entry gets picked. Idling on both sides is
  // switched in blocks, so some stretches run flat out.
  task automatic test_random_requests();
    int unsigned roll;
    int unsigned biggest;
    logic [REQ_W-1:0] size;
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 150 == 0) begin
        sender_idles = ($urandom_range(0, 3) != 0);
        receiver_idles = ($urandom_range(0, 3) != 0);
      end
      biggest = largest_free();
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        size = REQ_W'($urandom_range(1, 8));
      end else if (roll < 60) begin
        size = '0;
      end else if (roll < 64) begin
        size = REQ_W'(biggest);
      end else if (roll < 74) begin
        size = (biggest < MEM_SIZE) ? REQ_W'(biggest + 1) : REQ_W'(MEM_SIZE);
      end else if (roll < 86 && biggest != 0) begin
        size = REQ_W'($urandom_range(1, biggest));
      end else begin
        size = REQ_W'($urandom_range(0, MEM_SIZE));
      end
      send_request(size);
      // Once in a while the sender waits for the block to catch up fully.
      if (n % 400 == 399) begin
        wait_all_results();
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    clear_table();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_sizes();
    test_output_backpressure();
    test_random_requests();

    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && grants_due.size() == 0) begin
      $display("PASS worst_fit_block_allocator");
    end else begin
      $display("FAIL worst_fit_block_allocator");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/wfba_pkg.sv
rtl/wfba_cell.sv
rtl/worst_fit_block_allocator.sv
tb/sv/testbench.sv
